[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CFH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define CFH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/cfh_pkg.sv]
`default_nettype none
package cfh_pkg;

    localparam int MAX_PAYLOAD  = 64;
    localparam int MAX_CHANNELS = 32;
    localparam int PAY_AW = $clog2(MAX_PAYLOAD);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W  = $clog2(MAX_PAYLOAD + 8);
    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int TOT_W  = CH_W + 3;
    localparam int REC_W  = 7;
    localparam int NCH_W  = 6;
    localparam int IDX_W  = 4;
    localparam int TDATA_W = 32;

    localparam logic [7:0] SYM_START   = 8'h21; // '!'
    localparam logic [7:0] CMD_VERSION = 8'h56; // 'V'
    localparam logic [7:0] CMD_CONFIG  = 8'h43; // 'C'
    localparam logic [7:0] CMD_GO      = 8'h47; // 'G'
    localparam logic [7:0] CMD_STOP    = 8'h53; // 'S'
    localparam logic [7:0] CMD_ONCE    = 8'h49; // 'I'
    localparam logic [7:0] CMD_HELLO   = 8'h48; // 'H'
    localparam logic [7:0] CMD_MARK    = 8'h4D; // 'M'

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_ONCE  = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [7:0] TRIG_TIMED   = 8'd1;
    localparam logic [7:0] TRIG_PIN     = 8'd2;
    localparam logic [7:0] KIND_ANALOG  = 8'd1;
    localparam logic [7:0] KIND_DIGITAL = 8'd2;

    localparam logic [POS_W-1:0] HDR_TIMED = POS_W'(8);
    localparam logic [POS_W-1:0] HDR_PIN   = POS_W'(5);
    localparam logic [POS_W-1:0] HDR_PLAIN = POS_W'(3);

    localparam logic [REC_W-1:0] REC_BASE = REC_W'(8);
    localparam logic [REC_W-1:0] REC_MAX  = REC_W'(127);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } rx_phase_t;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_TRIG,
        DEC_CHK,
        DEC_KIND
    } dec_state_t;

    typedef struct packed {
        logic             valid;
        logic [7:0]       cmd;
        logic [LEN_W-1:0] len;
    } launch_t;

    typedef struct packed {
        logic [7:0]       trigger_kind;
        logic [CH_W-1:0]  channel_count;
        logic [REC_W-1:0] record_length;
    } setup_t;

    function automatic logic cmd_known(input logic [7:0] cmd);
        logic known;
        case (cmd)
            CMD_VERSION, CMD_CONFIG, CMD_GO, CMD_STOP,
            CMD_ONCE, CMD_HELLO, CMD_MARK: known = 1'b1;
            default:                       known = 1'b0;
        endcase
        return known;
    endfunction

    function automatic logic [2:0] cmd_action(input logic [7:0] cmd);
        logic [2:0] act;
        case (cmd)
            CMD_GO:    act = ACT_START;
            CMD_STOP:  act = ACT_STOP;
            CMD_ONCE:  act = ACT_ONCE;
            CMD_HELLO: act = ACT_CLEAR;
            default:   act = ACT_NONE;
        endcase
        return act;
    endfunction

    function automatic logic [7:0] text_len(input logic [7:0] cmd);
        logic [7:0] n;
        case (cmd)
            CMD_VERSION: n = 8'd5;
            CMD_HELLO:   n = 8'd3;
            default:     n = 8'd0;
        endcase
        return n;
    endfunction

    // "beta2" for V, "DAQ" for H
    function automatic logic [7:0] text_byte(input logic [7:0] cmd, input logic [2:0] k);
        logic [7:0] c;
        c = 8'h00;
        if (cmd == CMD_VERSION) begin
            case (k)
                3'd0:    c = 8'h62;
                3'd1:    c = 8'h65;
                3'd2:    c = 8'h74;
                3'd3:    c = 8'h61;
                3'd4:    c = 8'h32;
                default: c = 8'h00;
            endcase
        end else if (cmd == CMD_HELLO) begin
            case (k)
                3'd0:    c = 8'h44;
                3'd1:    c = 8'h41;
                3'd2:    c = 8'h51;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/cfh_ram.sv]
`default_nettype none
module cfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hdl/cfh_rx.sv]
`default_nettype none
module cfh_rx
    import cfh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [7:0]        in_data,
    input  wire logic              hold,
    output      logic              pay_we,
    output      logic [PAY_AW-1:0] pay_waddr,
    output      logic [7:0]        pay_wdata,
    output      launch_t           launch
);

    rx_phase_t        phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       sum_add;
    logic [LEN_W-1:0] count_inc;
    logic             accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign in_ready  = !hold;
    assign accept    = in_valid && in_ready;
    assign sum_add   = sum_reg + in_data;
    assign count_inc = count_reg + LEN_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        pay_we       = 1'b0;
        pay_waddr    = count_reg[PAY_AW-1:0];
        pay_wdata    = in_data;
        launch.valid = 1'b0;
        launch.cmd   = cmd_reg;
        launch.len   = len_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (accept && in_data == SYM_START) begin
                    sum_next   = in_data;
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                if (accept) begin
                    cmd_next   = in_data;
                    sum_next   = sum_add;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (accept) begin
                    if (in_data > 8'(MAX_PAYLOAD)) begin
                        phase_next = PH_HUNT;
                    end else begin
                        len_next   = in_data[LEN_W-1:0];
                        count_next = '0;
                        sum_next   = sum_add;
                        phase_next = (in_data != 8'd0) ? PH_DATA : PH_SUM;
                    end
                end
            end
            PH_DATA: begin
                if (accept) begin
                    pay_we     = 1'b1;
                    sum_next   = sum_add;
                    count_next = count_inc;
                    if (count_inc >= len_reg) begin
                        phase_next = PH_SUM;
                    end
                end
            end
            PH_SUM: begin
                if (accept) begin
                    sum_next     = sum_add;
                    phase_next   = PH_HUNT;
                    launch.valid = (sum_add == 8'd0) && cmd_known(cmd_reg);
                end
            end
            default: phase_next = PH_HUNT;
        endcase
    end

endmodule
`default_nettype wire

[hdl/cfh_dec.sv]
`default_nettype none
module cfh_dec
    import cfh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [LEN_W-1:0]  len,
    output      logic [PAY_AW-1:0] pay_raddr,
    input  wire logic [7:0]        pay_rdata,
    output      logic              busy,
    output      logic              done,
    output      setup_t            setup
);

    dec_state_t       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CH_W-1:0]  nch_reg, nch_next;
    logic [CH_W-1:0]  nana_reg, nana_next;
    logic [CH_W-1:0]  ndig_reg, ndig_next;
    logic [7:0]       trig_reg, trig_next;
    logic [CH_W-1:0]  chans_reg, chans_next;
    logic [REC_W-1:0] rec_reg, rec_next;
    logic [TOT_W-1:0] total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DEC_IDLE;
            trig_reg  <= '0;
            chans_reg <= '0;
            rec_reg   <= '0;
        end else begin
            state_reg <= state_next;
            trig_reg  <= trig_next;
            chans_reg <= chans_next;
            rec_reg   <= rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        nch_reg  <= nch_next;
        nana_reg <= nana_next;
        ndig_reg <= ndig_next;
    end

    // 8 timestamp bytes, 2 per analog channel, digital bits packed
    assign total = TOT_W'(8) + TOT_W'({nana_reg, 1'b0})
                 + TOT_W'((TOT_W'(ndig_reg) + TOT_W'(7)) >> 3);

    assign busy  = (state_reg != DEC_IDLE);
    assign setup.trigger_kind  = trig_reg;
    assign setup.channel_count = chans_reg;
    assign setup.record_length = rec_reg;

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        nch_next   = nch_reg;
        nana_next  = nana_reg;
        ndig_next  = ndig_reg;
        trig_next  = trig_reg;
        chans_next = chans_reg;
        rec_next   = rec_reg;
        pay_raddr  = '0;
        done       = 1'b0;
        case (state_reg)
            DEC_IDLE: begin
                if (start) begin
                    len_next = len;
                    if (len == '0) begin
                        trig_next  = 8'd0;
                        chans_next = '0;
                        rec_next   = REC_BASE;
                        done       = 1'b1;
                    end else begin
                        state_next = DEC_TRIG;
                    end
                end
            end
            DEC_TRIG: begin
                trig_next = pay_rdata;
                if (pay_rdata == TRIG_TIMED) begin
                    pos_next = HDR_TIMED;
                end else if (pay_rdata == TRIG_PIN) begin
                    pos_next = HDR_PIN;
                end else begin
                    pos_next = HDR_PLAIN;
                end
                nch_next   = '0;
                nana_next  = '0;
                ndig_next  = '0;
                state_next = DEC_CHK;
            end
            DEC_CHK: begin
                if (pos_reg < POS_W'(len_reg)) begin
                    pay_raddr  = pos_reg[PAY_AW-1:0];
                    state_next = DEC_KIND;
                end else begin
                    chans_next = nch_reg;
                    rec_next   = (total > TOT_W'(REC_MAX)) ? REC_MAX : total[REC_W-1:0];
                    done       = 1'b1;
                    state_next = DEC_IDLE;
                end
            end
            DEC_KIND: begin
                if (nch_reg < CH_W'(MAX_CHANNELS)) begin
                    nch_next = nch_reg + CH_W'(1);
                    if (pay_rdata == KIND_ANALOG) begin
                        nana_next = nana_reg + CH_W'(1);
                    end else if (pay_rdata == KIND_DIGITAL) begin
                        ndig_next = ndig_reg + CH_W'(1);
                    end
                end
                pos_next   = pos_reg + POS_W'(2);
                state_next = DEC_CHK;
            end
            default: state_next = DEC_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[hdl/cfh_tx.sv]
`default_nettype none
module cfh_tx
    import cfh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [7:0]         cmd,
    input  wire setup_t             setup,
    output      logic               busy,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [TDATA_W-1:0] out_data,
    output      logic               out_last
);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       tlen;
    logic [IDX_W-1:0] last_idx;
    logic [7:0]       tx_byte;
    logic             accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        sum_reg <= sum_next;
    end

    assign tlen     = text_len(cmd_reg);
    assign last_idx = tlen[IDX_W-1:0] + IDX_W'(3);
    assign out_last = (idx_reg == last_idx);
    assign busy     = busy_reg;
    assign out_valid = busy_reg;
    assign accept   = out_valid && out_ready;

    always_comb begin
        if (out_last) begin
            tx_byte = 8'd0 - sum_reg;
        end else begin
            case (idx_reg)
                IDX_W'(0): tx_byte = SYM_START;
                IDX_W'(1): tx_byte = cmd_reg;
                IDX_W'(2): tx_byte = tlen;
                default:   tx_byte = text_byte(cmd_reg, 3'(idx_reg - IDX_W'(3)));
            endcase
        end
    end

    // trigger_kind, channel_count, record_length, action, tx_byte
    assign out_data = {setup.trigger_kind, NCH_W'(setup.channel_count),
                       setup.record_length, cmd_action(cmd_reg), tx_byte};

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cmd_next  = cmd_reg;
        sum_next  = sum_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            cmd_next  = cmd;
            sum_next  = 8'd0;
        end else if (accept) begin
            sum_next = sum_reg + tx_byte;
            idx_next = idx_reg + IDX_W'(1);
            if (out_last) begin
                busy_next = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/command_frame_handler_top.sv]
`default_nettype none
`include "assert_macros.svh"
// Command frame handler. Takes received serial bytes one transfer at a time and
// recognizes frames of '!', command, length (at most 64), payload and a checksum
// that makes the 8-bit sum zero. Valid frames with a known command produce a reply
// frame of 4 to 9 transfers on the master side; tlast marks the checksum byte.
// Frame bytes are taken one per cycle. While a reply is pending, s_axis_tready is
// low. A 'C' frame is decoded from the 64-byte payload RAM through its single read
// port, reading first its trigger byte and then the kind byte of each channel entry,
// before its reply starts. The configuration outputs hold the result of the last 'C'
// frame and are zero after reset.
module command_frame_handler_top
    import cfh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    output      logic               s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,  // rx_byte
    output      logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // tx_byte[7:0], action[10:8], record_length[17:11], channel_count[23:18],
    // trigger_kind[31:24]
    output      logic [TDATA_W-1:0] m_axis_tdata,
    output      logic               m_axis_tlast   // last_byte
);

    logic              pay_we;
    logic [PAY_AW-1:0] pay_waddr;
    logic [7:0]        pay_wdata;
    logic [PAY_AW-1:0] pay_raddr;
    logic [7:0]        pay_rdata;
    launch_t           launch;
    setup_t            setup;
    logic              dec_busy;
    logic              dec_done;
    logic              dec_start;
    logic              tx_busy;
    logic              tx_start;
    logic [7:0]        tx_cmd;

    assign dec_start = launch.valid && (launch.cmd == CMD_CONFIG);
    assign tx_start  = (launch.valid && (launch.cmd != CMD_CONFIG)) || dec_done;
    assign tx_cmd    = dec_done ? CMD_CONFIG : launch.cmd;

    cfh_rx u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .hold      (dec_busy || tx_busy),
        .pay_we    (pay_we),
        .pay_waddr (pay_waddr),
        .pay_wdata (pay_wdata),
        .launch    (launch)
    );

    cfh_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    cfh_dec u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dec_start),
        .len       (launch.len),
        .pay_raddr (pay_raddr),
        .pay_rdata (pay_rdata),
        .busy      (dec_busy),
        .done      (dec_done),
        .setup     (setup)
    );

    cfh_tx u_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (tx_start),
        .cmd       (tx_cmd),
        .setup     (setup),
        .busy      (tx_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    `CFH_ASSERT_IMP(a_no_rx_during_reply, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `CFH_ASSERT_IMP(a_no_rx_during_decode, aclk, aresetn, dec_busy, !s_axis_tready)
    `CFH_ASSERT_NXT(a_reply_ends, aclk, aresetn, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
    `CFH_ASSERT_IMP(a_action_range, aclk, aresetn, m_axis_tvalid, m_axis_tdata[10:8] <= ACT_CLEAR)

endmodule
`default_nettype wire
